// ===== rtl/jmds_pkg.sv =====
// Shared types and constants for the JPEG marker dimension scanner.
package jmds_pkg;

   // Event kinds carried on the result channel.
   localparam logic [1:0] EV_DIMS   = 2'd0;
   localparam logic [1:0] EV_JPEG   = 2'd1;
   localparam logic [1:0] EV_REJECT = 2'd2;

   // Marker bytes.
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] CODE_SOI  = 8'hD8;
   localparam logic [7:0] CODE_EOI  = 8'hD9;
   localparam logic [7:0] CODE_SOS  = 8'hDA;
   localparam logic [7:0] CODE_SOF_LO = 8'hC0;
   localparam logic [7:0] CODE_SOF_HI = 8'hCF;
   localparam logic [7:0] CODE_DHT  = 8'hC4;
   localparam logic [7:0] CODE_JPG  = 8'hC8;
   localparam logic [7:0] CODE_DAC  = 8'hCC;

   // Result queue depth (entries of one bundle each).
   localparam int RESULT_DEPTH = 4;

   // Results caused by one input byte. When two_results is set the second
   // result is always a reject with the same dimensions.
   typedef struct packed {
      logic        push;
      logic [1:0]  first_kind;
      logic        two_results;
      logic [15:0] width;
      logic [15:0] height;
   } result_bundle_type;

endpackage

// ===== rtl/jmds_parser.sv =====
// Marker parser: phase register, segment counters and result bundle decode.
module jmds_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        stream_start,
   input  logic                        stream_end,
   output jmds_pkg::result_bundle_type bundle
);

   localparam logic [3:0] PH_SIG0     = 4'd0;
   localparam logic [3:0] PH_SIG1     = 4'd1;
   localparam logic [3:0] PH_HUNT     = 4'd2;
   localparam logic [3:0] PH_CODE     = 4'd3;
   localparam logic [3:0] PH_SKLEN_HI = 4'd4;
   localparam logic [3:0] PH_SKLEN_LO = 4'd5;
   localparam logic [3:0] PH_SKIPPING = 4'd6;
   localparam logic [3:0] PH_SFLEN_HI = 4'd7;
   localparam logic [3:0] PH_SFLEN_LO = 4'd8;
   localparam logic [3:0] PH_PREC     = 4'd9;
   localparam logic [3:0] PH_H_HI     = 4'd10;
   localparam logic [3:0] PH_H_LO     = 4'd11;
   localparam logic [3:0] PH_W_HI     = 4'd12;
   localparam logic [3:0] PH_W_LO     = 4'd13;
   localparam logic [3:0] PH_NCOMP    = 4'd14;
   localparam logic [3:0] PH_DONE     = 4'd15;

   logic [3:0]  phase_ff,  phase_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic [15:0] skip_ff,   skip_in;
   logic [7:0]  high_ff,   high_in;
   logic [15:0] width_ff,  width_in;
   logic [15:0] height_ff, height_in;

   logic [3:0]  phase_cur;
   logic [15:0] width_cur, height_cur;
   logic [15:0] word_val;
   logic [15:0] skip_dec;
   logic [9:0]  three_n;
   logic [15:0] sof_expect;
   logic        is_sof;

   // A stream start restarts the parser before this byte is looked at.
   assign phase_cur  = stream_start ? PH_SIG0 : phase_ff;
   assign width_cur  = stream_start ? 16'd0 : width_ff;
   assign height_cur = stream_start ? 16'd0 : height_ff;

   assign word_val   = {high_ff, data_byte};
   assign skip_dec   = skip_ff - 16'd1;
   assign three_n    = {1'b0, data_byte, 1'b0} + {2'b00, data_byte};
   assign sof_expect = {6'd0, three_n} + 16'd8;
   assign is_sof     = (data_byte >= jmds_pkg::CODE_SOF_LO) &&
                       (data_byte <= jmds_pkg::CODE_SOF_HI) &&
                       (data_byte != jmds_pkg::CODE_DHT) &&
                       (data_byte != jmds_pkg::CODE_JPG) &&
                       (data_byte != jmds_pkg::CODE_DAC);

   always_comb begin
      phase_in   = phase_cur;
      seg_len_in = seg_len_ff;
      skip_in    = skip_ff;
      high_in    = high_ff;
      width_in   = width_cur;
      height_in  = height_cur;
      bundle.push        = 1'b0;
      bundle.first_kind  = jmds_pkg::EV_REJECT;
      bundle.two_results = 1'b0;
      bundle.width       = width_cur;
      bundle.height      = height_cur;

      if (stream_end) begin
         if (phase_cur != PH_DONE) begin
            bundle.push = 1'b1;
            phase_in    = PH_DONE;
         end
      end else begin
         case (phase_cur)
            PH_SIG0: begin
               if (data_byte == jmds_pkg::BYTE_FF) begin
                  phase_in = PH_SIG1;
               end else begin
                  phase_in    = PH_DONE;
                  bundle.push = 1'b1;
               end
            end
            PH_SIG1: begin
               if (data_byte == jmds_pkg::CODE_SOI) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in    = PH_DONE;
                  bundle.push = 1'b1;
               end
            end
            PH_HUNT: begin
               if (data_byte == jmds_pkg::BYTE_FF) phase_in = PH_CODE;
            end
            PH_CODE: begin
               if (data_byte == jmds_pkg::BYTE_FF) begin
                  phase_in = PH_CODE;   // fill byte
               end else if (is_sof) begin
                  phase_in = PH_SFLEN_HI;
               end else if (data_byte == jmds_pkg::CODE_SOS ||
                            data_byte == jmds_pkg::CODE_EOI) begin
                  phase_in          = PH_DONE;
                  bundle.push       = 1'b1;
                  bundle.first_kind = jmds_pkg::EV_JPEG;
               end else begin
                  phase_in = PH_SKLEN_HI;
               end
            end
            PH_SKLEN_HI, PH_SFLEN_HI, PH_H_HI, PH_W_HI: begin
               high_in  = data_byte;
               phase_in = phase_cur + 4'd1;
            end
            PH_SKLEN_LO: begin
               seg_len_in = word_val;
               if (word_val < 16'd2) begin
                  phase_in    = PH_DONE;
                  bundle.push = 1'b1;
               end else begin
                  skip_in  = word_val - 16'd2;
                  phase_in = (word_val == 16'd2) ? PH_HUNT : PH_SKIPPING;
               end
            end
            PH_SKIPPING: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) phase_in = PH_HUNT;
            end
            PH_SFLEN_LO: begin
               seg_len_in = word_val;
               phase_in   = PH_PREC;
            end
            PH_PREC: begin
               phase_in = PH_H_HI;
            end
            PH_H_LO: begin
               height_in = word_val;
               phase_in  = PH_W_HI;
            end
            PH_W_LO: begin
               width_in = word_val;
               phase_in = PH_NCOMP;
            end
            PH_NCOMP: begin
               bundle.push       = 1'b1;
               bundle.first_kind = jmds_pkg::EV_DIMS;
               if (seg_len_ff != sof_expect) begin
                  bundle.two_results = 1'b1;
                  phase_in           = PH_DONE;
               end else begin
                  skip_in  = {6'd0, three_n};
                  phase_in = (three_n == 10'd0) ? PH_HUNT : PH_SKIPPING;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end

      if (!accept) bundle.push = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_len_ff <= seg_len_in;
         skip_ff    <= skip_in;
         high_ff    <= high_in;
      end
   end

   // A second result only follows a dimensions report.
   assert property (@(posedge clock) disable iff (reset)
      (bundle.push && bundle.two_results) |-> (bundle.first_kind == jmds_pkg::EV_DIMS))
      else $error("two results without a dimensions report first");

   // Once a verdict is reached, only a restart leaves the done phase.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && accept && !stream_start) |=> (phase_ff == PH_DONE))
      else $error("left done phase without a stream start");

   // An end of input can only ever reject, and with a single result.
   assert property (@(posedge clock) disable iff (reset)
      (bundle.push && stream_end) |->
         (bundle.first_kind == jmds_pkg::EV_REJECT && !bundle.two_results))
      else $error("end of input gave something other than one reject");

endmodule

// ===== rtl/jmds_result_fifo.sv =====
// Result queue: holds result bundles and serializes them onto the rsp channel.
module jmds_result_fifo #(
   parameter int DEPTH = jmds_pkg::RESULT_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  jmds_pkg::result_bundle_type wr_bundle,
   output logic                        has_room,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [1:0]                  out_kind,
   output logic [15:0]                 out_width,
   output logic [15:0]                 out_height,
   output logic                        out_last
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jmds_pkg::result_bundle_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             half_ff,   half_in;
   logic             push, pop, beat;

   jmds_pkg::result_bundle_type head;

   assign head      = entry_ff[rd_ptr_ff];
   assign has_room  = (count_ff < CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_kind  = half_ff ? jmds_pkg::EV_REJECT : head.first_kind;
   assign out_width = head.width;
   assign out_height = head.height;
   assign out_last  = half_ff | ~head.two_results;

   assign push = wr_bundle.push;
   assign beat = out_valid & out_ready;
   assign pop  = beat & out_last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      half_in   = half_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (!push && pop) count_in = count_ff - 1'b1;
      if (pop)       half_in = 1'b0;
      else if (beat) half_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= wr_bundle;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push |-> (has_room || pop))
      else $error("push into full result queue");

   assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (out_valid && head.two_results))
      else $error("second half sent for a single-result entry");

endmodule

// ===== rtl/jpeg_marker_dimension_scanner_unit.sv =====
// Top level of the JPEG marker dimension scanner.
//
//  channel | dir | tdata                              | tuser / tlast
//  --------+-----+------------------------------------+---------------------------------
//  req     | in  | [7:0] data_byte                    | tuser [0] stream_start, [1] stream_end
//  rsp     | out | [15:0] image_width, [31:16] height | tuser [1:0] event_kind; tlast
//
//  One byte transaction per cycle while req_tready is high. A byte is parsed
//  in the cycle it is accepted (phase register, counters) and its results
//  are written to the result queue at that cycle's clock edge, so rsp_tvalid
//  can rise in the cycle after an accepted byte. A byte that causes two results
//  (SOF length mismatch) occupies the rsp channel for two transactions; the
//  queue absorbs this while req keeps flowing. req_tready depends only on queue
//  occupancy; it drops when the queue is full because rsp is stalled. Synchronous
//  reset returns the parser to expecting the first FF and empties the queue.
module jpeg_marker_dimension_scanner_unit #(
   parameter int RESULT_DEPTH = jmds_pkg::RESULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] stream_start, [1] stream_end

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] image_width, [31:16] image_height
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast    // last result caused by this byte
);

   logic                        req_accept;
   jmds_pkg::result_bundle_type bundle;
   logic [15:0]                 out_width, out_height;

   assign req_accept = req_tvalid & req_tready;

   jmds_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_tdata),
      .stream_start (req_tuser[0]),
      .stream_end   (req_tuser[1]),
      .bundle       (bundle)
   );

   jmds_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_bundle  (bundle),
      .has_room   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_width  (out_width),
      .out_height (out_height),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {out_height, out_width};

endmodule

// ===== test/jpeg_marker_dimension_scanner_unit_test.sv =====
// Self-checking testbench for the JPEG marker dimension scanner unit.

// Parser phases of the scanner as tracked by the testbench.
typedef enum logic [4:0] {
   SCAN_SIG_FF,
   SCAN_SIG_SOI,
   SCAN_HUNT,
   SCAN_CODE,
   SCAN_SEG_LEN_HI,
   SCAN_SEG_LEN_LO,
   SCAN_SKIP,
   SCAN_SOF_LEN_HI,
   SCAN_SOF_LEN_LO,
   SCAN_PRECISION,
   SCAN_HEIGHT_HI,
   SCAN_HEIGHT_LO,
   SCAN_WIDTH_HI,
   SCAN_WIDTH_LO,
   SCAN_NCOMP,
   SCAN_DONE
} scan_phase_type;

typedef struct packed {
   logic [1:0]  kind;
   logic [15:0] width;
   logic [15:0] height;
   logic        last;
} scan_event_type;

// SOF0..SOF15, minus the DHT, JPG and DAC codes that share the range.
function automatic bit is_frame_code(logic [7:0] c);
   return c >= jmds_pkg::CODE_SOF_LO && c <= jmds_pkg::CODE_SOF_HI &&
          c != jmds_pkg::CODE_DHT && c != jmds_pkg::CODE_JPG && c != jmds_pkg::CODE_DAC;
endfunction

// Tracks the parser state for every accepted byte and holds the events it must emit.
class dimension_event_tracker;
   scan_phase_type phase;
   logic [15:0]    seg_len;
   logic [15:0]    skip_left;
   logic [7:0]     hi_hold;
   logic [15:0]    width_q;
   logic [15:0]    height_q;
   logic [7:0]     ncomp;
   scan_event_type step_ev[2];
   int             step_cnt;
   scan_event_type pending_events[$];
   int             error_count;

   function new();
      clear_parser();
      error_count = 0;
   endfunction

   function void clear_parser();
      phase     = SCAN_SIG_FF;
      seg_len   = '0;
      skip_left = '0;
      hi_hold   = '0;
      width_q   = '0;
      height_q  = '0;
      ncomp     = '0;
   endfunction

   function void emit(logic [1:0] kind);
      scan_event_type ev;
      ev.kind   = kind;
      ev.width  = width_q;
      ev.height = height_q;
      ev.last   = 1'b0;
      step_ev[step_cnt] = ev;
      step_cnt++;
   endfunction

   function void start_skip(logic [15:0] count);
      skip_left = count;
      phase = (count == 16'd0) ? SCAN_HUNT : SCAN_SKIP;
   endfunction

   function int pending_count();
      return pending_events.size();
   endfunction

   // One accepted byte transaction: advance the parser, queue what it emits.
   function void note_byte(logic [7:0] b, logic st, logic en);
      scan_event_type ev;
      logic [15:0]    comp_bytes;
      step_cnt = 0;
      if (st) clear_parser();
      if (en) begin
         if (phase != SCAN_DONE) begin
            emit(jmds_pkg::EV_REJECT);
            phase = SCAN_DONE;
         end
      end else begin
         case (phase)
            SCAN_SIG_FF: begin
               if (b == jmds_pkg::BYTE_FF) phase = SCAN_SIG_SOI;
               else begin
                  emit(jmds_pkg::EV_REJECT);
                  phase = SCAN_DONE;
               end
            end
            SCAN_SIG_SOI: begin
               if (b == jmds_pkg::CODE_SOI) phase = SCAN_HUNT;
               else begin
                  emit(jmds_pkg::EV_REJECT);
                  phase = SCAN_DONE;
               end
            end
            SCAN_HUNT: if (b == jmds_pkg::BYTE_FF) phase = SCAN_CODE;
            SCAN_CODE: begin
               if (b == jmds_pkg::BYTE_FF) begin
                  // fill byte, stay put
               end else if (is_frame_code(b)) begin
                  phase = SCAN_SOF_LEN_HI;
               end else if (b == jmds_pkg::CODE_SOS || b == jmds_pkg::CODE_EOI) begin
                  emit(jmds_pkg::EV_JPEG);
                  phase = SCAN_DONE;
               end else begin
                  phase = SCAN_SEG_LEN_HI;
               end
            end
            SCAN_SEG_LEN_HI: begin
               hi_hold = b;
               phase = SCAN_SEG_LEN_LO;
            end
            SCAN_SEG_LEN_LO: begin
               seg_len = {hi_hold, b};
               if (seg_len < 16'd2) begin
                  emit(jmds_pkg::EV_REJECT);
                  phase = SCAN_DONE;
               end else begin
                  start_skip(seg_len - 16'd2);
               end
            end
            SCAN_SKIP: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) phase = SCAN_HUNT;
            end
            SCAN_SOF_LEN_HI: begin
               hi_hold = b;
               phase = SCAN_SOF_LEN_LO;
            end
            SCAN_SOF_LEN_LO: begin
               seg_len = {hi_hold, b};
               phase = SCAN_PRECISION;
            end
            SCAN_PRECISION: phase = SCAN_HEIGHT_HI;
            SCAN_HEIGHT_HI: begin
               hi_hold = b;
               phase = SCAN_HEIGHT_LO;
            end
            SCAN_HEIGHT_LO: begin
               height_q = {hi_hold, b};
               phase = SCAN_WIDTH_HI;
            end
            SCAN_WIDTH_HI: begin
               hi_hold = b;
               phase = SCAN_WIDTH_LO;
            end
            SCAN_WIDTH_LO: begin
               width_q = {hi_hold, b};
               phase = SCAN_NCOMP;
            end
            SCAN_NCOMP: begin
               ncomp = b;
               emit(jmds_pkg::EV_DIMS);
               if (int'(seg_len) != 8 + 3 * int'(ncomp)) begin
                  emit(jmds_pkg::EV_REJECT);
                  phase = SCAN_DONE;
               end else begin
                  comp_bytes = 16'(3 * int'(ncomp));
                  start_skip(comp_bytes);
               end
            end
            SCAN_DONE: ;
            default: phase = SCAN_DONE;
         endcase
      end
      for (int i = 0; i < step_cnt; i++) begin
         ev = step_ev[i];
         ev.last = (i == step_cnt - 1);
         pending_events.push_back(ev);
      end
   endfunction

   task flag_mismatch(string msg);
      error_count++;
      if (error_count <= 40) $display("mismatch: %s", msg);
   endtask

   // One accepted result transaction against the oldest expected event.
   task check_event(logic [1:0] kind, logic [15:0] w, logic [15:0] h, logic last);
      scan_event_type want;
      if (pending_events.size() == 0) begin
         flag_mismatch($sformatf("unexpected result kind=%0d w=%0d h=%0d", kind, w, h));
      end else begin
         want = pending_events.pop_front();
         if (kind !== want.kind)
            flag_mismatch($sformatf("event kind %0d, want %0d", kind, want.kind));
         if (w !== want.width)
            flag_mismatch($sformatf("image width %0d, want %0d", w, want.width));
         if (h !== want.height)
            flag_mismatch($sformatf("image height %0d, want %0d", h, want.height));
         if (last !== want.last)
            flag_mismatch($sformatf("tlast %0b, want %0b", last, want.last));
      end
   endtask
endclass

module jpeg_marker_dimension_scanner_unit_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEM_TARGET = 700;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;  // [7:0] data_byte
   logic [1:0]  req_tuser  = 2'd0;  // [0] stream_start, [1] stream_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;          // [15:0] image_width, [31:16] image_height
   logic [1:0]  rsp_tuser;          // [1:0] event_kind
   logic        rsp_tlast;

   dimension_event_tracker tracker;
   logic [7:0] build_q[$];
   int         burst_left    = 0;
   bit         sender_idles  = 1'b1;
   int         rx_stall_pct  = 20;
   int         stall_left    = 0;
   int         items_sent    = 0;
   int         cycle_count   = 0;
   int         stream_idx    = 0;

   jpeg_marker_dimension_scanner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Input side noted before output side so ordering within the edge is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_byte(req_tdata, req_tuser[0], req_tuser[1]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_event(rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
      end
   end

   // Receiver: stall runs of random length at a per-phase rate.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = sender_idles ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {en, st};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold the sender until every expected event has been returned.
   task automatic drain_events();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.pending_count() != 0) @(posedge clock);
   endtask

   task automatic emit_stream(input bit with_start, input bit with_end);
      foreach (build_q[i]) send_byte(build_q[i], with_start && i == 0, 1'b0);
      if (with_end) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent += build_q.size() + int'(with_end);
      build_q.delete();
   endtask

   function automatic void put(logic [7:0] b);
      build_q.push_back(b);
   endfunction

   function automatic void put_word(logic [15:0] w);
      put(w[15:8]);
      put(w[7:0]);
   endfunction

   function automatic void add_fill(bit with_junk);
      int n;
      // non-FF bytes while hunting, then the marker prefix with optional pad FFs
      n = (with_junk && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) put(8'($urandom_range(0, 254)));
      put(jmds_pkg::BYTE_FF);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) put(jmds_pkg::BYTE_FF);
   endfunction

   function automatic logic [7:0] pick_plain_code();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == jmds_pkg::BYTE_FF || is_frame_code(c) ||
             c == jmds_pkg::CODE_EOI || c == jmds_pkg::CODE_SOS);
      return c;
   endfunction

   function automatic logic [15:0] pick_dimension();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void add_plain_segment();
      logic [15:0] len;
      add_fill(1'b1);
      put(pick_plain_code());
      len = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(256, 300))
                                         : 16'($urandom_range(2, 10));
      put_word(len);
      repeat (len - 2) put(8'($urandom_range(0, 255)));
   endfunction

   // Returns 1 when the length field was made inconsistent with the component count.
   function automatic bit add_frame_segment();
      logic [7:0]  c;
      logic [7:0]  n;
      logic [15:0] len;
      do c = 8'($urandom_range(jmds_pkg::CODE_SOF_LO, jmds_pkg::CODE_SOF_HI));
      while (!is_frame_code(c));
      case ($urandom_range(0, 19))
         0: n = 8'd0;
         1: n = 8'd255;
         2: n = 8'($urandom_range(5, 254));
         default: n = 8'($urandom_range(1, 4));
      endcase
      len = 16'd8 + 16'd3 * n;
      if ($urandom_range(0, 5) == 0) begin
         len = 16'($urandom_range(0, 65535));
         if (len == 16'd8 + 16'd3 * n) len = len + 16'd1;
      end
      add_fill(1'b1);
      put(c);
      put_word(len);
      put(8'($urandom_range(0, 255)));
      put_word(pick_dimension());
      put_word(pick_dimension());
      put(n);
      if (len != 16'd8 + 16'd3 * n) return 1'b1;
      repeat (3 * int'(n)) put(8'($urandom_range(0, 255)));
      return 1'b0;
   endfunction

   function automatic void build_good_stream();
      bit broken;
      broken = 1'b0;
      put(jmds_pkg::BYTE_FF);
      put(jmds_pkg::CODE_SOI);
      repeat ($urandom_range(0, 2)) add_plain_segment();
      if ($urandom_range(0, 3) != 0) broken = add_frame_segment();
      if (!broken) begin
         repeat ($urandom_range(0, 1)) add_plain_segment();
         add_fill(1'b1);
         put($urandom_range(0, 1) ? jmds_pkg::CODE_EOI : jmds_pkg::CODE_SOS);
      end
   endfunction

   initial begin
      int cut;
      int pick;
      tracker = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: no stream_start since reset; SOF with zero components and
      // full-scale dimensions, zero skip back to hunting, then EOI.
      sender_idles = 1'b0;
      put(jmds_pkg::BYTE_FF); put(jmds_pkg::CODE_SOI);
      put(jmds_pkg::BYTE_FF); put(jmds_pkg::CODE_SOF_LO);
      put_word(16'd8); put(8'd8); put_word(16'hFFFF); put_word(16'hFFFF); put(8'd0);
      put(jmds_pkg::BYTE_FF); put(jmds_pkg::CODE_EOI);
      emit_stream(1'b0, 1'b1);           // end after a verdict: silent
      put(8'h00);                        // bad first byte
      emit_stream(1'b1, 1'b0);
      send_byte(8'hA5, 1'b1, 1'b1);      // start and end together
      items_sent++;
      // pad FF ahead of an SOF whose length disagrees: dims then reject
      put(jmds_pkg::BYTE_FF); put(jmds_pkg::CODE_SOI);
      put(jmds_pkg::BYTE_FF); put(jmds_pkg::BYTE_FF);
      put(jmds_pkg::CODE_SOF_LO + 8'd1);
      put_word(16'd0); put(8'd8); put_word(16'd0); put_word(16'd0); put(8'd1);
      emit_stream(1'b1, 1'b0);
      put(jmds_pkg::BYTE_FF); put(8'h00);   // bad second byte
      emit_stream(1'b1, 1'b1);
      drain_events();

      while (items_sent < ITEM_TARGET) begin
         stream_idx++;
         if (stream_idx % 6 == 0) begin
            sender_idles = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 2);
            rx_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 60;
         end
         pick = $urandom_range(0, 11);
         if (pick <= 6) begin
            build_good_stream();
            emit_stream(1'b1, $urandom_range(0, 3) == 0);
         end else if (pick <= 8) begin
            // truncated stream ended early
            build_good_stream();
            cut = $urandom_range(1, build_q.size() - 1);
            while (build_q.size() > cut) void'(build_q.pop_back());
            emit_stream(1'b1, 1'b1);
         end else if (pick == 9) begin
            build_good_stream();
            build_q[$urandom_range(0, build_q.size() - 1)] = 8'($urandom_range(0, 255));
            emit_stream(1'b1, 1'($urandom_range(0, 1)));
         end else if (pick == 10) begin
            // non-SOF segment with a length below 2
            put(jmds_pkg::BYTE_FF); put(jmds_pkg::CODE_SOI);
            add_fill(1'b0);
            put(pick_plain_code());
            put_word(16'($urandom_range(0, 1)));
            emit_stream(1'b1, 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
               items_sent++;
            end else begin
               repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
               emit_stream(1'b1, 1'($urandom_range(0, 1)));
            end
         end
         // trailing bytes without a stream start; the parser ignores them after a verdict
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         if (stream_idx % 10 == 0) drain_events();
      end

      drain_events();
      repeat (10) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
